>>> sv/pcl_pkg.sv
// Package for the half-plane polygon clipper: widths, word and config types,
// controller state encodings and the shared signed multiply.
// No dependencies; every other file refers to it by scoped names.
package pcl_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int FIELD_W         = 32;
  localparam int DIFF_W          = COORD_WIDTH + 1;
  localparam int OP_W            = DIFF_W + 1;
  localparam int MUL_W           = 2 * OP_W;
  localparam int CROSS_W         = 2 * COORD_WIDTH + 3;
  localparam int MAG_W           = CROSS_W - 1;
  localparam int EPS_W           = 41;
  localparam int PROD_W          = MAG_W + DIFF_W;
  localparam int NUM2_W          = PROD_W + 1;
  localparam int QB              = 41;
  localparam int DIV_W           = MAG_W + 1 + QB;
  localparam int QCNT_W          = $clog2(QB);
  localparam int SUM_W           = QB + 2;
  localparam int CNT_W           = 2;
  localparam int MIN_RING_POINTS = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = EPS_W;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [OP_W-1:0]        op_t;
  typedef logic signed [MUL_W-1:0]       prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUT_START_X  = 3'd0,
    CFG_CUT_START_Y  = 3'd1,
    CFG_CUT_END_X    = 3'd2,
    CFG_CUT_END_Y    = 3'd3,
    CFG_KEEP_LEFT    = 3'd4,
    CFG_SIDE_EPSILON = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    coord_t             sx;
    coord_t             sy;
    coord_t             ex;
    coord_t             ey;
    logic               keep_left;
    logic [EPS_W-1:0]   eps;
  } cfg_t;

  // One classified vertex as handed from the front to the back.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t fx;
    coord_t fy;
    logic   last;
    logic   cin;
    logic   fin;
  } vq_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_MUL0,
    FR_MUL1,
    FR_SIDE,
    FR_PUSH
  } front_st_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_EDGE,
    B_D0,
    B_D1,
    B_N0,
    B_N1,
    B_NUM,
    B_P0,
    B_P1,
    B_P2,
    B_DSET,
    B_DIV,
    B_FIN,
    B_EMIT_X,
    B_EMIT_B,
    B_NEXT,
    B_MARK
  } back_st_t;

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic prod_t mul_op(op_t a, op_t b);
    return MUL_W'(a) * MUL_W'(b);
  endfunction

endpackage

>>> sv/pcl_front.sv
// Front end of the clipper: accepts vertex words and classifies them against
// the cutter line (and the ring's first vertex on the closing word).
// Depends on pcl_pkg.
module pcl_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pcl_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [pcl_pkg::FIELD_W-1:0] in_vertex_x,
  input  logic signed [pcl_pkg::FIELD_W-1:0] in_vertex_y,
  input  logic                            in_last_vertex,
  input  pcl_pkg::q_stat_t                q_stat,
  output logic                            q_push,
  output pcl_pkg::vq_t                    q_wdata
);

  pcl_pkg::front_st_t st_r, st_nxt;
  pcl_pkg::coord_t    vx_r, vy_r, fx_r, fy_r;
  logic               last_r, have_first_r, pass_r, cin_r, fin_r;
  pcl_pkg::prod_t     p0_r, p1_r;

  pcl_pkg::coord_t    pt_x, pt_y;
  pcl_pkg::diff_t     dxc, dyc;
  pcl_pkg::prod_t     side, eps_p, sum_l, sum_r;
  logic               kept;

  always_comb begin
    pt_x   = pass_r ? fx_r : vx_r;
    pt_y   = pass_r ? fy_r : vy_r;
    dxc    = pcl_pkg::sub_c(cfg.ex, cfg.sx);
    dyc    = pcl_pkg::sub_c(cfg.ey, cfg.sy);
    side   = p0_r - p1_r;
    eps_p  = pcl_pkg::prod_t'(cfg.eps);
    sum_l  = side + eps_p;
    sum_r  = eps_p - side;
    kept   = cfg.keep_left ? !sum_l[pcl_pkg::MUL_W-1] : !sum_r[pcl_pkg::MUL_W-1];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pcl_pkg::FR_IDLE: if (in_valid) st_nxt = pcl_pkg::FR_MUL0;
      pcl_pkg::FR_MUL0: st_nxt = pcl_pkg::FR_MUL1;
      pcl_pkg::FR_MUL1: st_nxt = pcl_pkg::FR_SIDE;
      pcl_pkg::FR_SIDE: st_nxt = (!pass_r && last_r) ? pcl_pkg::FR_MUL0 : pcl_pkg::FR_PUSH;
      pcl_pkg::FR_PUSH: if (!q_stat.full) st_nxt = pcl_pkg::FR_IDLE;
      default:          st_nxt = pcl_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (st_r != pcl_pkg::FR_IDLE);
    q_push   = (st_r == pcl_pkg::FR_PUSH) && !q_stat.full;
    q_wdata  = '{x: vx_r, y: vy_r, fx: fx_r, fy: fy_r,
                 last: last_r, cin: cin_r, fin: fin_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= pcl_pkg::FR_IDLE;
      have_first_r <= 1'b0;
      pass_r       <= 1'b0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        pcl_pkg::FR_IDLE: if (in_valid) begin
          vx_r         <= in_vertex_x[pcl_pkg::COORD_WIDTH-1:0];
          vy_r         <= in_vertex_y[pcl_pkg::COORD_WIDTH-1:0];
          last_r       <= in_last_vertex;
          pass_r       <= 1'b0;
          have_first_r <= !in_last_vertex;
          if (!have_first_r) begin
            fx_r <= in_vertex_x[pcl_pkg::COORD_WIDTH-1:0];
            fy_r <= in_vertex_y[pcl_pkg::COORD_WIDTH-1:0];
          end
        end
        pcl_pkg::FR_MUL0:
          p0_r <= pcl_pkg::mul_op(pcl_pkg::OP_W'(dxc),
                                  pcl_pkg::OP_W'(pcl_pkg::sub_c(pt_y, cfg.sy)));
        pcl_pkg::FR_MUL1:
          p1_r <= pcl_pkg::mul_op(pcl_pkg::OP_W'(dyc),
                                  pcl_pkg::OP_W'(pcl_pkg::sub_c(pt_x, cfg.sx)));
        pcl_pkg::FR_SIDE: begin
          if (pass_r) fin_r <= kept;
          else        cin_r <= kept;
          if (!pass_r && last_r) pass_r <= 1'b1;
        end
        pcl_pkg::FR_PUSH: ;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/pcl_queue.sv
// Short queue of classified vertex words between the front and the back.
// Depends on pcl_pkg.
module pcl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pcl_pkg::vq_t     wdata,
  input  logic             pop,
  output pcl_pkg::vq_t     head,
  output pcl_pkg::q_stat_t stat
);

  pcl_pkg::vq_t                 mem_r [pcl_pkg::QUEUE_DEPTH];
  logic [pcl_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [pcl_pkg::QCOUNT_W-1:0] count_r;

  always_comb begin
    head       = mem_r[rd_ptr_r];
    stat.full  = (count_r == pcl_pkg::QCOUNT_W'(pcl_pkg::QUEUE_DEPTH));
    stat.empty = (count_r == '0);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

>>> sv/pcl_back.sv
// Back end of the clipper: walks ring edges, computes crossing points with a
// shared multiplier and a bit-serial divider, and drives the result register.
// Depends on pcl_pkg.
module pcl_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pcl_pkg::cfg_t                      cfg,
  input  pcl_pkg::q_stat_t                   q_stat,
  input  pcl_pkg::vq_t                       q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pcl_pkg::FIELD_W-1:0] out_point_x,
  output logic signed [pcl_pkg::FIELD_W-1:0] out_point_y,
  output logic                               out_is_point,
  output logic                               out_end_of_ring,
  output logic                               out_ring_ok
);

  pcl_pkg::back_st_t st_r, st_nxt;
  pcl_pkg::vq_t      e_r;
  pcl_pkg::coord_t   prev_x_r, prev_y_r, ax_r, ay_r, bx_r, by_r, resx_r, resy_r;
  logic              prev_in_r, have_first_r, ain_r, bin_r, closing_r, coord_r;
  logic [pcl_pkg::CNT_W-1:0]  cnt_r;
  pcl_pkg::prod_t             p_r, acc_r;
  logic [pcl_pkg::MAG_W-1:0]  dmag_r, nmag_r;
  logic                       dneg_r, nneg_r, ovf_r;
  logic [pcl_pkg::PROD_W-1:0] pacc_r;
  logic [pcl_pkg::DIV_W-1:0]  rem_r, dsh_r;
  logic [pcl_pkg::QB-1:0]     q_r;
  logic [pcl_pkg::QCNT_W-1:0] qcnt_r;

  logic                         out_valid_r, out_is_point_r, out_end_r, out_ok_r;
  pcl_pkg::coord_t              out_x_r, out_y_r;

  logic                         can_load, out_load, near, ge, neg;
  pcl_pkg::diff_t               sxc, syc, r_c;
  logic [pcl_pkg::DIFF_W-1:0]   rmag;
  pcl_pkg::op_t                 ma, mb;
  logic signed [pcl_pkg::CROSS_W-1:0] cdiff;
  logic [pcl_pkg::MAG_W-1:0]    cmag;
  logic [pcl_pkg::NUM2_W-1:0]   num2;
  logic [pcl_pkg::MAG_W:0]      den2;
  logic [pcl_pkg::QB-1:0]       qm;
  pcl_pkg::coord_t              a_c, sat;
  logic signed [pcl_pkg::SUM_W-1:0] qs, sum;
  logic [pcl_pkg::SUM_W-pcl_pkg::COORD_WIDTH:0] top_bits;

  localparam logic [pcl_pkg::QB-1:0] QLIMIT = pcl_pkg::QB'(1) << (pcl_pkg::QB - 1);

  // Datapath helpers.
  always_comb begin
    can_load = !out_valid_r || !out_stall;
    sxc      = pcl_pkg::sub_c(cfg.ex, cfg.sx);
    syc      = pcl_pkg::sub_c(cfg.ey, cfg.sy);
    r_c      = coord_r ? pcl_pkg::sub_c(by_r, ay_r) : pcl_pkg::sub_c(bx_r, ax_r);
    rmag     = r_c[pcl_pkg::DIFF_W-1] ? $unsigned(-r_c) : $unsigned(r_c);
    a_c      = coord_r ? ay_r : ax_r;
    cdiff    = pcl_pkg::CROSS_W'(acc_r - p_r);
    cmag     = pcl_pkg::MAG_W'(cdiff[pcl_pkg::CROSS_W-1] ? $unsigned(-cdiff)
                                                        : $unsigned(cdiff));
    near     = (dmag_r <= pcl_pkg::MAG_W'(cfg.eps));
    num2     = pcl_pkg::NUM2_W'({pacc_r, 1'b0}) + pcl_pkg::NUM2_W'(dmag_r);
    den2     = {dmag_r, 1'b0};
    ge       = (rem_r >= dsh_r);
    qm       = (ovf_r || (q_r > QLIMIT)) ? QLIMIT : q_r;
    neg      = nneg_r ^ r_c[pcl_pkg::DIFF_W-1] ^ dneg_r;
    qs       = $signed(pcl_pkg::SUM_W'(qm));
    sum      = pcl_pkg::SUM_W'(a_c) + (neg ? -qs : qs);
    top_bits = sum[pcl_pkg::SUM_W-1:pcl_pkg::COORD_WIDTH-1];
    if ((&top_bits) || !(|top_bits)) sat = sum[pcl_pkg::COORD_WIDTH-1:0];
    else if (sum[pcl_pkg::SUM_W-1])  sat = {1'b1, {(pcl_pkg::COORD_WIDTH-1){1'b0}}};
    else                             sat = {1'b0, {(pcl_pkg::COORD_WIDTH-1){1'b1}}};
  end

  // Multiplier operand select: signed differences sign extend, magnitude
  // chunks zero extend.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      pcl_pkg::B_D0: begin
        ma = pcl_pkg::OP_W'(pcl_pkg::sub_c(bx_r, ax_r));
        mb = pcl_pkg::OP_W'(syc);
      end
      pcl_pkg::B_D1: begin
        ma = pcl_pkg::OP_W'(pcl_pkg::sub_c(by_r, ay_r));
        mb = pcl_pkg::OP_W'(sxc);
      end
      pcl_pkg::B_N0: begin
        ma = pcl_pkg::OP_W'(pcl_pkg::sub_c(cfg.sx, ax_r));
        mb = pcl_pkg::OP_W'(syc);
      end
      pcl_pkg::B_N1: begin
        ma = pcl_pkg::OP_W'(pcl_pkg::sub_c(cfg.sy, ay_r));
        mb = pcl_pkg::OP_W'(sxc);
      end
      pcl_pkg::B_P0: begin
        ma = $signed(pcl_pkg::OP_W'(nmag_r[pcl_pkg::DIFF_W-1:0]));
        mb = $signed(pcl_pkg::OP_W'(rmag));
      end
      pcl_pkg::B_P1: begin
        ma = $signed(pcl_pkg::OP_W'(nmag_r[pcl_pkg::MAG_W-1:pcl_pkg::DIFF_W]));
        mb = $signed(pcl_pkg::OP_W'(rmag));
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pcl_pkg::B_IDLE:
        if (!q_stat.empty) st_nxt = have_first_r ? pcl_pkg::B_EDGE : pcl_pkg::B_NEXT;
      pcl_pkg::B_EDGE:
        if (ain_r ^ bin_r) st_nxt = pcl_pkg::B_D0;
        else               st_nxt = bin_r ? pcl_pkg::B_EMIT_B : pcl_pkg::B_NEXT;
      pcl_pkg::B_D0:   st_nxt = pcl_pkg::B_D1;
      pcl_pkg::B_D1:   st_nxt = pcl_pkg::B_N0;
      pcl_pkg::B_N0:   st_nxt = pcl_pkg::B_N1;
      pcl_pkg::B_N1:   st_nxt = near ? pcl_pkg::B_EMIT_X : pcl_pkg::B_NUM;
      pcl_pkg::B_NUM:  st_nxt = pcl_pkg::B_P0;
      pcl_pkg::B_P0:   st_nxt = pcl_pkg::B_P1;
      pcl_pkg::B_P1:   st_nxt = pcl_pkg::B_P2;
      pcl_pkg::B_P2:   st_nxt = pcl_pkg::B_DSET;
      pcl_pkg::B_DSET:
        st_nxt = ((pcl_pkg::DIV_W'(num2)) >= (pcl_pkg::DIV_W'(den2) << pcl_pkg::QB))
                 ? pcl_pkg::B_FIN : pcl_pkg::B_DIV;
      pcl_pkg::B_DIV:  if (qcnt_r == '0) st_nxt = pcl_pkg::B_FIN;
      pcl_pkg::B_FIN:  st_nxt = coord_r ? pcl_pkg::B_EMIT_X : pcl_pkg::B_P0;
      pcl_pkg::B_EMIT_X:
        if (can_load) st_nxt = bin_r ? pcl_pkg::B_EMIT_B : pcl_pkg::B_NEXT;
      pcl_pkg::B_EMIT_B: if (can_load) st_nxt = pcl_pkg::B_NEXT;
      pcl_pkg::B_NEXT:
        if (e_r.last && !closing_r) st_nxt = pcl_pkg::B_EDGE;
        else if (e_r.last)          st_nxt = pcl_pkg::B_MARK;
        else                        st_nxt = pcl_pkg::B_IDLE;
      pcl_pkg::B_MARK: if (can_load) st_nxt = pcl_pkg::B_IDLE;
      default: st_nxt = pcl_pkg::B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop    = (st_r == pcl_pkg::B_IDLE) && !q_stat.empty;
    out_load = can_load && ((st_r == pcl_pkg::B_EMIT_X) || (st_r == pcl_pkg::B_EMIT_B) ||
                            (st_r == pcl_pkg::B_MARK));
    out_valid       = out_valid_r;
    out_point_x     = pcl_pkg::FIELD_W'(out_x_r);
    out_point_y     = pcl_pkg::FIELD_W'(out_y_r);
    out_is_point    = out_is_point_r;
    out_end_of_ring = out_end_r;
    out_ring_ok     = out_ok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= pcl_pkg::B_IDLE;
      have_first_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      closing_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;

      if (out_load)                      out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (st_r)
        pcl_pkg::B_IDLE: if (!q_stat.empty) begin
          e_r       <= q_head;
          closing_r <= 1'b0;
          ax_r      <= prev_x_r;
          ay_r      <= prev_y_r;
          ain_r     <= prev_in_r;
          bx_r      <= q_head.x;
          by_r      <= q_head.y;
          bin_r     <= q_head.cin;
          prev_x_r  <= q_head.x;
          prev_y_r  <= q_head.y;
          prev_in_r <= q_head.cin;
          if (!have_first_r) begin
            have_first_r <= 1'b1;
            cnt_r        <= '0;
          end
        end
        pcl_pkg::B_D0: p_r <= pcl_pkg::mul_op(ma, mb);
        pcl_pkg::B_D1: begin
          acc_r <= p_r;
          p_r   <= pcl_pkg::mul_op(ma, mb);
        end
        pcl_pkg::B_N0: begin
          dmag_r <= cmag;
          dneg_r <= cdiff[pcl_pkg::CROSS_W-1];
          p_r    <= pcl_pkg::mul_op(ma, mb);
        end
        pcl_pkg::B_N1: begin
          // Near-parallel edge: the crossing collapses onto the edge's end.
          if (near) begin
            resx_r <= bx_r;
            resy_r <= by_r;
          end
          acc_r <= p_r;
          p_r   <= pcl_pkg::mul_op(ma, mb);
        end
        pcl_pkg::B_NUM: begin
          nmag_r  <= cmag;
          nneg_r  <= cdiff[pcl_pkg::CROSS_W-1];
          coord_r <= 1'b0;
        end
        pcl_pkg::B_P0: p_r <= pcl_pkg::mul_op(ma, mb);
        pcl_pkg::B_P1: begin
          pacc_r <= pcl_pkg::PROD_W'($unsigned(p_r));
          p_r    <= pcl_pkg::mul_op(ma, mb);
        end
        pcl_pkg::B_P2:
          pacc_r <= pacc_r + (pcl_pkg::PROD_W'($unsigned(p_r)) << pcl_pkg::DIFF_W);
        pcl_pkg::B_DSET: begin
          ovf_r  <= (pcl_pkg::DIV_W'(num2)) >= (pcl_pkg::DIV_W'(den2) << pcl_pkg::QB);
          rem_r  <= pcl_pkg::DIV_W'(num2);
          dsh_r  <= pcl_pkg::DIV_W'(den2) << (pcl_pkg::QB - 1);
          q_r    <= '0;
          qcnt_r <= pcl_pkg::QCNT_W'(pcl_pkg::QB - 1);
        end
        pcl_pkg::B_DIV: begin
          if (ge) rem_r <= rem_r - dsh_r;
          q_r    <= {q_r[pcl_pkg::QB-2:0], ge};
          dsh_r  <= dsh_r >> 1;
          qcnt_r <= qcnt_r - 1'b1;
        end
        pcl_pkg::B_FIN: begin
          if (coord_r) resy_r <= sat;
          else         resx_r <= sat;
          coord_r <= 1'b1;
        end
        pcl_pkg::B_EMIT_X: if (can_load) begin
          out_x_r        <= resx_r;
          out_y_r        <= resy_r;
          out_is_point_r <= 1'b1;
          out_end_r      <= 1'b0;
          out_ok_r       <= 1'b0;
          if (cnt_r != pcl_pkg::CNT_W'(pcl_pkg::MIN_RING_POINTS)) cnt_r <= cnt_r + 1'b1;
        end
        pcl_pkg::B_EMIT_B: if (can_load) begin
          out_x_r        <= bx_r;
          out_y_r        <= by_r;
          out_is_point_r <= 1'b1;
          out_end_r      <= 1'b0;
          out_ok_r       <= 1'b0;
          if (cnt_r != pcl_pkg::CNT_W'(pcl_pkg::MIN_RING_POINTS)) cnt_r <= cnt_r + 1'b1;
        end
        pcl_pkg::B_NEXT: if (e_r.last && !closing_r) begin
          // Closing edge: last vertex back to the held first vertex.
          closing_r <= 1'b1;
          ax_r      <= e_r.x;
          ay_r      <= e_r.y;
          ain_r     <= e_r.cin;
          bx_r      <= e_r.fx;
          by_r      <= e_r.fy;
          bin_r     <= e_r.fin;
        end
        pcl_pkg::B_MARK: if (can_load) begin
          out_x_r        <= '0;
          out_y_r        <= '0;
          out_is_point_r <= 1'b0;
          out_end_r      <= 1'b1;
          out_ok_r       <= (cnt_r == pcl_pkg::CNT_W'(pcl_pkg::MIN_RING_POINTS));
          have_first_r   <= 1'b0;
          cnt_r          <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/polygon_half_plane_clipper_core.sv
// Top level of the half-plane polygon clipper; instantiates pcl_front,
// pcl_queue and pcl_back and holds the configuration registers.
// Depends on pcl_pkg.
//
// Streams the vertices of one polygon ring (last_vertex on the final one) and
// clips the ring against the kept side of the configured cutter line. Each
// ring edge yields its crossing point and/or its kept end vertex; the ring's
// first vertex is held and the closing edge is clipped when the last vertex
// arrives, so the output ring is rotated by one edge. A marker word
// (is_point 0, end_of_ring 1) closes every ring, with ring_ok set if three or
// more points came out. The front classifies a vertex with two multiplies
// and a side test, and repeats them for the held first vertex on the closing
// word. The back skips the arithmetic on an edge without a crossing; on a
// crossing one shared 34x34 multiplier does the cross products and two partial
// products per coordinate, and a restoring divider produces one quotient bit a
// cycle (41 bits per coordinate). The closing word can carry up to two
// crossings; a two-entry queue lets the front take the next word while the
// back works. No clearing pass after reset. Write configuration only while
// the block is idle.
module polygon_half_plane_clipper_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // vertex input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pcl_pkg::FIELD_W-1:0]    in_vertex_x,
  input  logic signed [pcl_pkg::FIELD_W-1:0]    in_vertex_y,
  input  logic                                  in_last_vertex,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pcl_pkg::FIELD_W-1:0]    out_point_x,
  output logic signed [pcl_pkg::FIELD_W-1:0]    out_point_y,
  output logic                                  out_is_point,
  output logic                                  out_end_of_ring,
  output logic                                  out_ring_ok,
  // configuration write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pcl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pcl_pkg::CFG_DATA_W-1:0]        cfg_data
);

  pcl_pkg::cfg_t    cfg_r;
  pcl_pkg::q_stat_t q_stat;
  pcl_pkg::vq_t     q_wdata, q_head;
  logic             q_push, q_pop;

  // Always take a config word; registers outside the list drop the write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sx        <= '0;
      cfg_r.sy        <= '0;
      cfg_r.ex        <= pcl_pkg::COORD_WIDTH'(65536);
      cfg_r.ey        <= '0;
      cfg_r.keep_left <= 1'b1;
      cfg_r.eps       <= pcl_pkg::EPS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (pcl_pkg::cfg_idx_t'(cfg_index))
        pcl_pkg::CFG_CUT_START_X:  cfg_r.sx        <= cfg_data[pcl_pkg::COORD_WIDTH-1:0];
        pcl_pkg::CFG_CUT_START_Y:  cfg_r.sy        <= cfg_data[pcl_pkg::COORD_WIDTH-1:0];
        pcl_pkg::CFG_CUT_END_X:    cfg_r.ex        <= cfg_data[pcl_pkg::COORD_WIDTH-1:0];
        pcl_pkg::CFG_CUT_END_Y:    cfg_r.ey        <= cfg_data[pcl_pkg::COORD_WIDTH-1:0];
        pcl_pkg::CFG_KEEP_LEFT:    cfg_r.keep_left <= cfg_data[0];
        pcl_pkg::CFG_SIDE_EPSILON: cfg_r.eps       <= cfg_data[pcl_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept and classify each vertex word.
  pcl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // Hold classified words so each side stalls on its own.
  pcl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  // Back: clip edges, compute crossings, drive the result register.
  pcl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_stat          (q_stat),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_is_point    (out_is_point),
    .out_end_of_ring (out_end_of_ring),
    .out_ring_ok     (out_ring_ok)
  );

endmodule

>>> sv/pcl_checker.sv
// Port-level checks for the half-plane polygon clipper, bound to the top level.
// Depends on pcl_pkg.
module pcl_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic signed [pcl_pkg::FIELD_W-1:0] in_vertex_x,
  input logic signed [pcl_pkg::FIELD_W-1:0] in_vertex_y,
  input logic                               in_last_vertex,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [pcl_pkg::FIELD_W-1:0] out_point_x,
  input logic signed [pcl_pkg::FIELD_W-1:0] out_point_y,
  input logic                               out_is_point,
  input logic                               out_end_of_ring,
  input logic                               out_ring_ok,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [pcl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [pcl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // A word is either a ring point or the end marker, never both.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_point != out_end_of_ring))
    else $error("result word is neither a point nor a marker, or both");

  // The marker carries no coordinates.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_ring |-> (out_point_x == '0) && (out_point_y == '0))
    else $error("end marker carries coordinates");

  // ring_ok only on the marker.
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_point |-> !out_ring_ok)
    else $error("ring_ok set on a ring point");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x) &&
                               $stable(out_point_y) && $stable(out_end_of_ring))
    else $error("stalled result changed");

  // Nothing comes out in the cycle after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind polygon_half_plane_clipper_core pcl_checker u_pcl_checker (.*);

>>> bench/polygon_half_plane_clipper_core_test.sv
// Self-checking bench for polygon_half_plane_clipper_core: drives rings of
// vertices, predicts every clipped ring word and compares the result stream.
// Depends on pcl_pkg and polygon_half_plane_clipper_core.
module polygon_half_plane_clipper_core_test;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } vertex_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        is_point;
    logic        end_of_ring;
    logic        ring_ok;
  } ring_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [pcl_pkg::FIELD_W-1:0]   in_vertex_x = '0;
  logic signed [pcl_pkg::FIELD_W-1:0]   in_vertex_y = '0;
  logic                                 in_last_vertex = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [pcl_pkg::FIELD_W-1:0]   out_point_x;
  logic signed [pcl_pkg::FIELD_W-1:0]   out_point_y;
  logic                                 out_is_point;
  logic                                 out_end_of_ring;
  logic                                 out_ring_ok;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [pcl_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
  logic [pcl_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

  polygon_half_plane_clipper_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y),
    .in_last_vertex(in_last_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_is_point(out_is_point), .out_end_of_ring(out_end_of_ring),
    .out_ring_ok(out_ring_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bench copy of the cutter registers and the ring state.
  longint   cut_sx, cut_sy, cut_ex, cut_ey;
  logic     cut_keep_left;
  logic [40:0] cut_eps;
  longint   ring_fx, ring_fy, ring_px, ring_py;
  logic     ring_pin, ring_open;
  int       ring_points;

  vertex_t    pending_vertices[$];
  ring_word_t expected_words[$];
  int         mismatches = 0;
  int         in_gap = 0;
  int         out_hold = 0;
  bit         in_idle_on = 1'b1;
  bit         out_idle_on = 1'b1;

  function automatic wide_t cross2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
    return ax * by - ay * bx;
  endfunction

  // Side test with tolerance; keep_left keeps side >= -eps, else side <= eps.
  function automatic logic kept_side(longint px, longint py);
    wide_t side, eps;
    side = cross2(cut_ex - cut_sx, cut_ey - cut_sy, px - cut_sx, py - cut_sy);
    eps = wide_t'({87'd0, cut_eps});
    if (cut_keep_left) return side >= -eps;
    return side <= eps;
  endfunction

  // Round half away from zero, magnitude clamped to 2^40.
  function automatic longint rounded_quotient(wide_t n, wide_t d);
    wide_t un, ud, q;
    logic  neg;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (2 * un + ud) / (2 * ud);
    if (q > (wide_t'(1) <<< 40)) q = wide_t'(1) <<< 40;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void add_point(longint x, longint y);
    ring_word_t w;
    w.x = x[31:0];
    w.y = y[31:0];
    w.is_point = 1'b1;
    w.end_of_ring = 1'b0;
    w.ring_ok = 1'b0;
    expected_words = {expected_words, w};
    if (ring_points < pcl_pkg::MIN_RING_POINTS) ring_points++;
  endfunction

  function automatic void add_crossing(longint ax, longint ay, longint bx, longint by);
    wide_t sx, sy, rx, ry, den, num, eps;
    sx = cut_ex - cut_sx;
    sy = cut_ey - cut_sy;
    rx = bx - ax;
    ry = by - ay;
    den = cross2(rx, ry, sx, sy);
    eps = wide_t'({87'd0, cut_eps});
    // near-parallel edge: fall back to the end vertex
    if (((den < 0) ? -den : den) <= eps) begin
      add_point(bx, by);
      return;
    end
    num = cross2(cut_sx - ax, cut_sy - ay, sx, sy);
    add_point(clamp_coord(ax + rounded_quotient(num * rx, den)),
              clamp_coord(ay + rounded_quotient(num * ry, den)));
  endfunction

  function automatic void clip_ring_edge(longint ax, longint ay, logic ain,
                                         longint bx, longint by, logic bin);
    if (bin) begin
      if (!ain) add_crossing(ax, ay, bx, by);
      add_point(bx, by);
    end else if (ain) begin
      add_crossing(ax, ay, bx, by);
    end
  endfunction

  function automatic void predict_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                                         logic last);
    longint     x, y;
    logic       cin;
    ring_word_t m;
    x = vx;
    y = vy;
    cin = kept_side(x, y);
    if (!ring_open) begin
      ring_fx = x;
      ring_fy = y;
      ring_open = 1'b1;
      ring_points = 0;
    end else begin
      clip_ring_edge(ring_px, ring_py, ring_pin, x, y, cin);
    end
    ring_px = x;
    ring_py = y;
    ring_pin = cin;
    if (last) begin
      // close the ring; the first vertex is classified with today's registers
      clip_ring_edge(x, y, cin, ring_fx, ring_fy, kept_side(ring_fx, ring_fy));
      m.x = '0;
      m.y = '0;
      m.is_point = 1'b0;
      m.end_of_ring = 1'b1;
      m.ring_ok = ring_points >= pcl_pkg::MIN_RING_POINTS;
      expected_words = {expected_words, m};
      ring_open = 1'b0;
      ring_points = 0;
    end
  endfunction

  // Driver: launch the next pending word after its drawn gap, predict on accept.
  always @(posedge clk) begin
    vertex_t v;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) predict_vertex(in_vertex_x, in_vertex_y, in_last_vertex);
      if (!in_valid || !in_stall) begin
        if (in_gap == 0 && pending_vertices.size() > 0) begin
          v = pending_vertices.pop_front();
          in_vertex_x <= v.x;
          in_vertex_y <= v.y;
          in_last_vertex <= v.last;
          in_valid <= 1'b1;
          in_gap <= in_idle_on ? $urandom_range(0, 17) : 0;
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest expectation, then
  // draw how long to stall before the next one.
  always @(posedge clk) begin
    ring_word_t e;
    int         hold_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else begin
      hold_next = out_hold;
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word x=%h y=%h pt=%b eor=%b ok=%b", out_point_x,
                     out_point_y, out_is_point, out_end_of_ring, out_ring_ok);
        end else begin
          e = expected_words.pop_front();
          if (e.x !== out_point_x || e.y !== out_point_y || e.is_point !== out_is_point ||
              e.end_of_ring !== out_end_of_ring || e.ring_ok !== out_ring_ok) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch exp x=%h y=%h pt=%b eor=%b ok=%b",
                        " got x=%h y=%h pt=%b eor=%b ok=%b"},
                       e.x, e.y, e.is_point, e.end_of_ring, e.ring_ok, out_point_x,
                       out_point_y, out_is_point, out_end_of_ring, out_ring_ok);
          end
        end
        hold_next = out_idle_on ? $urandom_range(0, 17) : 0;
      end else if (hold_next > 0) begin
        hold_next--;
      end
      out_hold <= hold_next;
      out_stall <= hold_next != 0;
    end
  end

  task automatic write_reg(pcl_pkg::cfg_idx_t idx, logic [40:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pcl_pkg::CFG_CUT_START_X:  cut_sx = longint'($signed(value[31:0]));
      pcl_pkg::CFG_CUT_START_Y:  cut_sy = longint'($signed(value[31:0]));
      pcl_pkg::CFG_CUT_END_X:    cut_ex = longint'($signed(value[31:0]));
      pcl_pkg::CFG_CUT_END_Y:    cut_ey = longint'($signed(value[31:0]));
      pcl_pkg::CFG_KEEP_LEFT:    cut_keep_left = value[0];
      pcl_pkg::CFG_SIDE_EPSILON: cut_eps = value;
      default: ;
    endcase
  endtask

  task automatic set_cutter(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                            logic [31:0] ey, logic keep, logic [40:0] eps);
    write_reg(pcl_pkg::CFG_CUT_START_X, {9'd0, sx});
    write_reg(pcl_pkg::CFG_CUT_START_Y, {9'd0, sy});
    write_reg(pcl_pkg::CFG_CUT_END_X, {9'd0, ex});
    write_reg(pcl_pkg::CFG_CUT_END_Y, {9'd0, ey});
    write_reg(pcl_pkg::CFG_KEEP_LEFT, {40'd0, keep});
    write_reg(pcl_pkg::CFG_SIDE_EPSILON, eps);
    cfg_valid <= 1'b0;
  endtask

  // Wait until everything sent has come back, then let the back end drain.
  // Sample on the falling edge so the driver's updates have settled.
  task automatic drain();
    @(negedge clk);
    while (pending_vertices.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic last);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.last = last;
    pending_vertices = {pending_vertices, v};
  endtask

  function automatic logic [31:0] pick_coord(bit want_x);
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2:       return want_x ? cut_sx[31:0] : cut_sy[31:0];
      3:       return want_x ? cut_ex[31:0] : cut_ey[31:0];
      default: return 32'($signed($urandom_range(0, 511)) - 256) <<< 16;
    endcase
  endfunction

  // Rings of random content; mostly whole rings, sometimes repeated or
  // collinear vertices, and at most one ring left open across a phase.
  task automatic add_rings(int count, bit leave_open);
    int          n;
    logic [31:0] x, y;
    repeat (count) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      x = pick_coord(1);
      y = pick_coord(0);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) != 0) begin
          x = pick_coord(1);
          y = pick_coord(0);
        end
        add_vertex(x, y, i == n - 1);
      end
    end
    if (leave_open) add_vertex(pick_coord(1), pick_coord(0), 1'b0);
  endtask

  function automatic logic [40:0] pick_eps();
    case ($urandom_range(0, 4))
      0:       return 41'd0;
      1:       return 41'd1 << 40;
      2:       return {9'd0, $urandom};
      3:       return {1'b0, 8'($urandom_range(0, 255)), 32'd0};
      default: return 41'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [31:0] sx, sy, ex, ey;
    cut_sx = 0;
    cut_sy = 0;
    cut_ex = 65536;
    cut_ey = 0;
    cut_keep_left = 1'b1;
    cut_eps = 41'd1;
    ring_open = 1'b0;
    ring_points = 0;
    ring_fx = 0;
    ring_fy = 0;
    ring_px = 0;
    ring_py = 0;
    ring_pin = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rings on the reset cutter (x axis, keep the upper side).
    add_vertex(32'h0001_0000, 32'h0001_0000, 1'b1);          // lone vertex kept
    add_vertex(32'h0001_0000, 32'hffff_0000, 1'b1);          // lone vertex dropped
    add_vertex(32'h0000_0000, 32'h0002_0000, 1'b0);          // two-point ring
    add_vertex(32'h0002_0000, 32'hfffe_0000, 1'b1);
    add_vertex(32'h0000_0000, 32'h0001_0000, 1'b0);          // triangle across line
    add_vertex(32'h0003_0000, 32'hffff_0000, 1'b0);
    add_vertex(32'h0004_0000, 32'h0002_0000, 1'b1);
    add_vertex(32'h0000_0000, 32'h0000_0000, 1'b0);          // vertices on the line
    add_vertex(32'h0005_0000, 32'h0000_0000, 1'b0);
    add_vertex(32'h0005_0000, 32'h0005_0000, 1'b1);
    add_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);          // coordinate extremes
    add_vertex(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    add_vertex(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_vertex(32'h7fff_ffff, 32'h8000_0000, 1'b1);
    add_vertex(32'h0001_0000, 32'h0000_0001, 1'b0);          // edge nearly on the line
    add_vertex(32'h0009_0000, 32'hffff_ffff, 1'b0);
    add_vertex(32'h0004_0000, 32'hfff0_0000, 1'b1);
    drain();

    // Extreme cutters, then random ones; hold idling off in some phases.
    set_cutter(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0,
               41'd1 << 40);
    add_rings(4, 1'b0);
    drain();
    set_cutter(32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1, 41'd0);
    add_rings(4, 1'b1);
    drain();
    for (int phase = 0; phase < 9; phase++) begin
      in_idle_on = $urandom_range(0, 2) != 0;
      out_idle_on = $urandom_range(0, 2) != 0;
      sx = pick_coord(1);
      sy = pick_coord(0);
      ex = ($urandom_range(0, 3) == 0) ? sx : pick_coord(1);
      ey = pick_coord(0);
      set_cutter(sx, sy, ex, ey, 1'($urandom_range(0, 1)), pick_eps());
      add_rings(6, $urandom_range(0, 3) == 0);
      drain();
    end
    // close any ring left open
    add_vertex(32'h0001_0000, 32'h0002_0000, 1'b1);
    drain();

    if (expected_words.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Generous wall: far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> polygon_half_plane_clipper_core.f
sv/pcl_pkg.sv
sv/pcl_front.sv
sv/pcl_queue.sv
sv/pcl_back.sv
sv/polygon_half_plane_clipper_core.sv
sv/pcl_checker.sv
bench/polygon_half_plane_clipper_core_test.sv
